// ===== rtl/cma_pkg.sv =====
`default_nettype none
package cma_pkg;

   localparam int MAX_BLOCKS_DEF = 16;
   localparam int ADDR_BITS_DEF  = 16;
   localparam int OWNER_BITS_DEF = 8;

   localparam logic [15:0] TOTAL_RESET = 16'hFFFF;

   localparam logic [1:0] OP_REQUEST = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_COMPACT = 2'd2;
   localparam logic [1:0] OP_STATUS  = 2'd3;

   // 'F', 'B', 'W'
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic [2:0] RC_OK      = 3'd0;
   localparam logic [2:0] RC_NOMEM   = 3'd1;
   localparam logic [2:0] RC_NOOWNER = 3'd2;
   localparam logic [2:0] RC_FULL    = 3'd3;
   localparam logic [2:0] RC_BADFIT  = 3'd4;

endpackage
`default_nettype wire

// ===== rtl/cma_mem.sv =====
`default_nettype none
module cma_mem #(
   parameter int DEPTH = cma_pkg::MAX_BLOCKS_DEF,
   parameter int WIDTH = 2 * cma_pkg::ADDR_BITS_DEF + cma_pkg::OWNER_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/contiguous_memory_allocator.sv =====
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | operation, owner_id, request_size, fit_strategy
// rsp     | out       | rsp_valid / rsp_ready | result_code, block_start, block_size,
//         |           |                       | block_owner, last
// csr     | in        | csr_wr_en             | csr_wr_data (total_size)
//
// One word at a time; the block table sits in a one-read one-write memory and every
// step of an operation reads a table entry, then uses it.
// A request scans the table, then shifts entries up to split a hole; a release finds the
// owner, then merges free neighbours; compact packs in one pass; status waits on stalls.
// After reset or a csr write, the INIT state rebuilds the single hole before req_ready rises.
// The result register lets the next word in while a result waits on rsp_ready.
`default_nettype none
module contiguous_memory_allocator #(
   parameter int MAX_BLOCKS = cma_pkg::MAX_BLOCKS_DEF,
   parameter int ADDR_BITS  = cma_pkg::ADDR_BITS_DEF,
   parameter int OWNER_BITS = cma_pkg::OWNER_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_owner_id,
   input  wire logic [15:0] req_request_size,
   input  wire logic [1:0]  req_fit_strategy,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_result_code,
   output logic [15:0]      rsp_block_start,
   output logic [15:0]      rsp_block_size,
   output logic [7:0]       rsp_block_owner,
   output logic             rsp_last
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int EW    = 2 * ADDR_BITS + OWNER_BITS;
   localparam int ACC_W = ADDR_BITS + CNT_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_INIT   = 5'd1;
   localparam logic [4:0] S_RQ_RD  = 5'd2;
   localparam logic [4:0] S_RQ_EV  = 5'd3;
   localparam logic [4:0] S_RQ_DEC = 5'd4;
   localparam logic [4:0] S_SH_RD  = 5'd5;
   localparam logic [4:0] S_SH_WR  = 5'd6;
   localparam logic [4:0] S_SPL_A  = 5'd7;
   localparam logic [4:0] S_SPL_B  = 5'd8;
   localparam logic [4:0] S_FD_RD  = 5'd9;
   localparam logic [4:0] S_FD_EV  = 5'd10;
   localparam logic [4:0] S_MG_RD  = 5'd11;
   localparam logic [4:0] S_MG_EV  = 5'd12;
   localparam logic [4:0] S_MG_END = 5'd13;
   localparam logic [4:0] S_CP_RD  = 5'd14;
   localparam logic [4:0] S_CP_EV  = 5'd15;
   localparam logic [4:0] S_CP_END = 5'd16;
   localparam logic [4:0] S_ST_RD  = 5'd17;
   localparam logic [4:0] S_ST_EV  = 5'd18;
   localparam logic [4:0] S_RESP   = 5'd19;

   logic [4:0]            state_ff, state_in;
   logic [15:0]           total_ff;
   logic [1:0]            op_ff, op_in;
   logic [OWNER_BITS-1:0] own_ff, own_in;
   logic [ADDR_BITS-1:0]  size_ff, size_in;
   logic [1:0]            fit_ff, fit_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in, idx_ff, idx_in, wr_ff, wr_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      pick_ff, pick_in;
   logic [ADDR_BITS-1:0]  pstart_ff, pstart_in, psize_ff, psize_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [EW-1:0]         prev_ff, prev_in;
   logic [2:0]            code_ff, code_in;

   logic                  rv_ff, rv_in, rlast_ff, rlast_in;
   logic [2:0]            rcode_ff, rcode_in;
   logic [15:0]           rstart_ff, rstart_in, rsize_ff, rsize_in;
   logic [7:0]            rown_ff, rown_in;

   logic                  mem_we;
   logic [IDX_W-1:0]      mem_wa, mem_ra;
   logic [EW-1:0]         mem_wd, mem_rd;

   logic [OWNER_BITS-1:0] e_own, m_own;
   logic [ADDR_BITS-1:0]  e_size, e_start, total_a;
   logic                  is_last, out_free, fits;
   logic [ACC_W-1:0]      total_x;

   cma_mem #(.DEPTH(MAX_BLOCKS), .WIDTH(EW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   assign e_own    = mem_rd[OWNER_BITS-1:0];
   assign e_size   = mem_rd[OWNER_BITS +: ADDR_BITS];
   assign e_start  = mem_rd[OWNER_BITS+ADDR_BITS +: ADDR_BITS];
   assign m_own    = (e_own == own_ff) ? '0 : e_own;
   assign is_last  = (idx_ff == cnt_ff - CNT_ONE);
   assign out_free = !rv_ff || rsp_ready;
   assign total_a  = ADDR_BITS'(total_ff);
   assign total_x  = ACC_W'(total_a);
   assign fits     = (e_own == '0) && (e_size >= size_ff);

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rv_ff;
   assign rsp_result_code = rcode_ff;
   assign rsp_block_start = rstart_ff;
   assign rsp_block_size  = rsize_ff;
   assign rsp_block_owner = rown_ff;
   assign rsp_last        = rlast_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      own_in    = own_ff;
      size_in   = size_ff;
      fit_in    = fit_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      wr_in     = wr_ff;
      found_in  = found_ff;
      pick_in   = pick_ff;
      pstart_in = pstart_ff;
      psize_in  = psize_ff;
      acc_in    = acc_ff;
      prev_in   = prev_ff;
      code_in   = code_ff;
      rv_in     = rv_ff && !rsp_ready;
      rcode_in  = rcode_ff;
      rstart_in = rstart_ff;
      rsize_in  = rsize_ff;
      rown_in   = rown_ff;
      rlast_in  = rlast_ff;
      mem_we    = 1'b0;
      mem_wa    = wr_ff[IDX_W-1:0];
      mem_wd    = prev_ff;
      mem_ra    = idx_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               own_in   = OWNER_BITS'(req_owner_id);
               size_in  = ADDR_BITS'(req_request_size);
               fit_in   = req_fit_strategy;
               idx_in   = '0;
               wr_in    = '0;
               found_in = 1'b0;
               acc_in   = '0;
               code_in  = cma_pkg::RC_OK;
               case (req_operation)
                  cma_pkg::OP_REQUEST: begin
                     if (req_fit_strategy > cma_pkg::FIT_WORST) begin
                        code_in  = cma_pkg::RC_BADFIT;
                        state_in = S_RESP;
                     end else if (OWNER_BITS'(req_owner_id) == '0) begin
                        code_in  = cma_pkg::RC_NOOWNER;
                        state_in = S_RESP;
                     end else if (ADDR_BITS'(req_request_size) == '0) begin
                        code_in  = cma_pkg::RC_NOMEM;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_RQ_RD;
                     end
                  end
                  cma_pkg::OP_RELEASE: begin
                     if (OWNER_BITS'(req_owner_id) == '0) begin
                        code_in  = cma_pkg::RC_NOOWNER;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_FD_RD;
                     end
                  end
                  cma_pkg::OP_COMPACT: state_in = S_CP_RD;
                  default:             state_in = S_ST_RD;
               endcase
            end
         end
         S_INIT: begin
            mem_we   = 1'b1;
            mem_wa   = '0;
            mem_wd   = {{ADDR_BITS{1'b0}}, total_a, {OWNER_BITS{1'b0}}};
            cnt_in   = CNT_ONE;
            state_in = S_IDLE;
         end
         S_RQ_RD: state_in = S_RQ_EV;
         S_RQ_EV: begin
            if (fits && (!found_ff
                  || (fit_ff == cma_pkg::FIT_BEST && e_size < psize_ff)
                  || (fit_ff == cma_pkg::FIT_WORST && e_size > psize_ff))) begin
               found_in  = 1'b1;
               pick_in   = idx_ff[IDX_W-1:0];
               pstart_in = e_start;
               psize_in  = e_size;
            end
            idx_in   = idx_ff + CNT_ONE;
            state_in = is_last ? S_RQ_DEC : S_RQ_RD;
         end
         S_RQ_DEC: begin
            if (!found_ff) begin
               code_in  = cma_pkg::RC_NOMEM;
               state_in = S_RESP;
            end else if (psize_ff > size_ff && cnt_ff == CNT_MAX) begin
               code_in  = cma_pkg::RC_FULL;
               state_in = S_RESP;
            end else if (psize_ff > size_ff) begin
               idx_in   = cnt_ff;
               state_in = S_SH_RD;
            end else begin
               state_in = S_SPL_B;
            end
         end
         S_SH_RD: begin
            mem_ra = IDX_W'(idx_ff - CNT_ONE);
            if (idx_ff > CNT_W'(pick_ff) + CNT_ONE) begin
               state_in = S_SH_WR;
            end else begin
               state_in = S_SPL_A;
            end
         end
         S_SH_WR: begin
            mem_we   = 1'b1;
            mem_wa   = idx_ff[IDX_W-1:0];
            mem_wd   = mem_rd;
            idx_in   = idx_ff - CNT_ONE;
            state_in = S_SH_RD;
         end
         S_SPL_A: begin
            mem_we   = 1'b1;
            mem_wa   = pick_ff + IDX_W'(1);
            mem_wd   = {pstart_ff + size_ff, psize_ff - size_ff, {OWNER_BITS{1'b0}}};
            cnt_in   = cnt_ff + CNT_ONE;
            state_in = S_SPL_B;
         end
         S_SPL_B: begin
            mem_we   = 1'b1;
            mem_wa   = pick_ff;
            mem_wd   = {pstart_ff, size_ff, own_ff};
            state_in = S_RESP;
         end
         S_FD_RD: state_in = S_FD_EV;
         S_FD_EV: begin
            if (e_own == own_ff) begin
               found_in = 1'b1;
            end
            idx_in = idx_ff + CNT_ONE;
            if (!is_last) begin
               state_in = S_FD_RD;
            end else if (found_ff || e_own == own_ff) begin
               idx_in   = '0;
               state_in = S_MG_RD;
            end else begin
               code_in  = cma_pkg::RC_NOOWNER;
               state_in = S_RESP;
            end
         end
         S_MG_RD: state_in = S_MG_EV;
         S_MG_EV: begin
            if (idx_ff == '0) begin
               prev_in = {e_start, e_size, m_own};
            end else if (prev_ff[OWNER_BITS-1:0] == '0 && m_own == '0) begin
               prev_in[OWNER_BITS +: ADDR_BITS] = prev_ff[OWNER_BITS +: ADDR_BITS] + e_size;
            end else begin
               mem_we  = 1'b1;
               wr_in   = wr_ff + CNT_ONE;
               prev_in = {e_start, e_size, m_own};
            end
            idx_in   = idx_ff + CNT_ONE;
            state_in = is_last ? S_MG_END : S_MG_RD;
         end
         S_MG_END: begin
            mem_we   = 1'b1;
            cnt_in   = wr_ff + CNT_ONE;
            state_in = S_RESP;
         end
         S_CP_RD: state_in = S_CP_EV;
         S_CP_EV: begin
            if (e_own != '0) begin
               mem_we = 1'b1;
               mem_wd = {acc_ff[ADDR_BITS-1:0], e_size, e_own};
               acc_in = acc_ff + ACC_W'(e_size);
               wr_in  = wr_ff + CNT_ONE;
            end
            idx_in   = idx_ff + CNT_ONE;
            state_in = is_last ? S_CP_END : S_CP_RD;
         end
         S_CP_END: begin
            cnt_in = wr_ff;
            if ((acc_ff < total_x || wr_ff == '0) && wr_ff < CNT_MAX) begin
               mem_we = 1'b1;
               mem_wd = {acc_ff[ADDR_BITS-1:0],
                         (acc_ff < total_x) ? ADDR_BITS'(total_x - acc_ff) : '0,
                         {OWNER_BITS{1'b0}}};
               cnt_in = wr_ff + CNT_ONE;
            end
            state_in = S_RESP;
         end
         S_ST_RD: state_in = S_ST_EV;
         S_ST_EV: begin
            if (out_free) begin
               rv_in     = 1'b1;
               rcode_in  = cma_pkg::RC_OK;
               rstart_in = 16'(e_start);
               rsize_in  = 16'(e_size);
               rown_in   = 8'(e_own);
               rlast_in  = is_last;
               idx_in    = idx_ff + CNT_ONE;
               state_in  = is_last ? S_IDLE : S_ST_RD;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rcode_in = code_ff;
               rlast_in = 1'b1;
               if (op_ff == cma_pkg::OP_REQUEST && code_ff == cma_pkg::RC_OK) begin
                  rstart_in = 16'(pstart_ff);
                  rsize_in  = 16'(size_ff);
                  rown_in   = 8'(own_ff);
               end else begin
                  rstart_in = '0;
                  rsize_in  = '0;
                  rown_in   = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_wr_en) begin
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         total_ff <= cma_pkg::TOTAL_RESET;
         cnt_ff   <= CNT_ONE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
         if (csr_wr_en) begin
            total_ff <= csr_wr_data;
         end
      end
      op_ff     <= op_in;
      own_ff    <= own_in;
      size_ff   <= size_in;
      fit_ff    <= fit_in;
      idx_ff    <= idx_in;
      wr_ff     <= wr_in;
      found_ff  <= found_in;
      pick_ff   <= pick_in;
      pstart_ff <= pstart_in;
      psize_ff  <= psize_in;
      acc_ff    <= acc_in;
      prev_ff   <= prev_in;
      code_ff   <= code_in;
      rcode_ff  <= rcode_in;
      rstart_ff <= rstart_in;
      rsize_ff  <= rsize_in;
      rown_ff   <= rown_in;
      rlast_ff  <= rlast_in;
   end

endmodule
`default_nettype wire

// ===== rtl/cma_checker.sv =====
`default_nettype none
module cma_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_result_code,
   input wire logic [15:0] rsp_block_start,
   input wire logic [15:0] rsp_block_size,
   input wire logic        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while busy");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_code != cma_pkg::RC_OK |-> rsp_last)
      else $error("error result not final");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_code != cma_pkg::RC_OK
         |-> rsp_block_start == 16'd0 && rsp_block_size == 16'd0)
      else $error("error result carries block data");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_code <= cma_pkg::RC_BADFIT)
      else $error("result code out of range");

endmodule

bind contiguous_memory_allocator cma_checker u_cma_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_code (rsp_result_code),
   .rsp_block_start (rsp_block_start),
   .rsp_block_size  (rsp_block_size),
   .rsp_last        (rsp_last)
);
`default_nettype wire

// ===== tb/contiguous_memory_allocator_test.sv =====
`default_nettype none
module contiguous_memory_allocator_test;

   localparam int NBLK = cma_pkg::MAX_BLOCKS_DEF;
   localparam logic [1:0] FIT_INVALID = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  owner_id;
      logic [15:0] request_size;
      logic [1:0]  fit_strategy;
   } alloc_cmd_type;

   typedef struct packed {
      logic [2:0]  result_code;
      logic [15:0] block_start;
      logic [15:0] block_size;
      logic [7:0]  block_owner;
      logic        last;
   } alloc_rsp_type;

   typedef struct {
      alloc_cmd_type cmd;
      logic          known;
      alloc_rsp_type rsp;
   } directed_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [15:0] csr_wr_data = '0;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_operation = '0;
   logic [7:0]  req_owner_id = '0;
   logic [15:0] req_request_size = '0;
   logic [1:0]  req_fit_strategy = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_result_code;
   logic [15:0] rsp_block_start;
   logic [15:0] rsp_block_size;
   logic [7:0]  rsp_block_owner;
   logic        rsp_last;

   contiguous_memory_allocator i_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_owner_id(req_owner_id),
      .req_request_size(req_request_size), .req_fit_strategy(req_fit_strategy),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_code(rsp_result_code), .rsp_block_start(rsp_block_start),
      .rsp_block_size(rsp_block_size), .rsp_block_owner(rsp_block_owner),
      .rsp_last(rsp_last)
   );

   always #1 clock = ~clock;

   // table shadow
   logic [15:0] tbl_start [NBLK];
   logic [15:0] tbl_size  [NBLK];
   logic [7:0]  tbl_owner [NBLK];
   int          tbl_count;
   logic [15:0] mem_total;

   alloc_rsp_type pending_rsp [$];
   int            errors = 0;
   int            send_idle = 0;
   int            recv_idle = 0;
   logic          hold_rsp = 0;

   function automatic void queue_word(alloc_rsp_type r);
      pending_rsp.insert(pending_rsp.size(), r);
   endfunction

   function automatic alloc_rsp_type mk_rsp(logic [2:0] c, logic [15:0] s, logic [15:0] z,
                                            logic [7:0] o, logic l);
      alloc_rsp_type r;
      r.result_code = c; r.block_start = s; r.block_size = z;
      r.block_owner = o; r.last = l;
      return r;
   endfunction

   function automatic void table_init();
      for (int i = 0; i < NBLK; i++) begin
         tbl_start[i] = '0; tbl_size[i] = '0; tbl_owner[i] = '0;
      end
      tbl_size[0] = mem_total;
      tbl_count = 1;
   endfunction

   function automatic void drop_entry(int idx);
      for (int i = idx; i + 1 < tbl_count; i++) begin
         tbl_start[i] = tbl_start[i+1]; tbl_size[i] = tbl_size[i+1];
         tbl_owner[i] = tbl_owner[i+1];
      end
      tbl_count--;
      tbl_start[tbl_count] = '0; tbl_size[tbl_count] = '0; tbl_owner[tbl_count] = '0;
   endfunction

   function automatic logic [2:0] grant(logic [7:0] own, logic [15:0] sz, logic [1:0] fit,
                                        output logic [15:0] gstart);
      int pick;
      bit found;
      pick = 0; found = 0; gstart = '0;
      if (fit > cma_pkg::FIT_WORST) return cma_pkg::RC_BADFIT;
      if (own == 0) return cma_pkg::RC_NOOWNER;
      if (sz == 0) return cma_pkg::RC_NOMEM;
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_owner[i] != 0 || tbl_size[i] < sz) continue;
         if (!found) begin
            pick = i; found = 1;
            if (fit == cma_pkg::FIT_FIRST) break;
         end else if (fit == cma_pkg::FIT_BEST && tbl_size[i] < tbl_size[pick]) begin
            pick = i;
         end else if (fit == cma_pkg::FIT_WORST && tbl_size[i] > tbl_size[pick]) begin
            pick = i;
         end
      end
      if (!found) return cma_pkg::RC_NOMEM;
      if (tbl_size[pick] > sz) begin
         if (tbl_count >= NBLK) return cma_pkg::RC_FULL;
         for (int i = tbl_count; i > pick + 1; i--) begin
            tbl_start[i] = tbl_start[i-1]; tbl_size[i] = tbl_size[i-1];
            tbl_owner[i] = tbl_owner[i-1];
         end
         tbl_start[pick+1] = tbl_start[pick] + sz;
         tbl_size[pick+1] = tbl_size[pick] - sz;
         tbl_owner[pick+1] = '0;
         tbl_size[pick] = sz;
         tbl_count++;
      end
      tbl_owner[pick] = own;
      gstart = tbl_start[pick];
      return cma_pkg::RC_OK;
   endfunction

   function automatic logic [2:0] free_owner(logic [7:0] own);
      bit found;
      int i;
      found = 0;
      if (own == 0) return cma_pkg::RC_NOOWNER;
      for (i = 0; i < tbl_count; i++)
         if (tbl_owner[i] == own) begin
            tbl_owner[i] = '0; found = 1;
         end
      if (!found) return cma_pkg::RC_NOOWNER;
      i = 0;
      while (i + 1 < tbl_count) begin
         if (tbl_owner[i] == 0 && tbl_owner[i+1] == 0) begin
            tbl_size[i] = tbl_size[i] + tbl_size[i+1];
            drop_entry(i + 1);
         end else begin
            i++;
         end
      end
      return cma_pkg::RC_OK;
   endfunction

   function automatic void pack_table();
      int n;
      longint addr;
      n = 0; addr = 0;
      for (int i = 0; i < tbl_count; i++)
         if (tbl_owner[i] != 0) begin
            tbl_start[n] = addr[15:0]; tbl_size[n] = tbl_size[i];
            tbl_owner[n] = tbl_owner[i];
            addr += tbl_size[i]; n++;
         end
      if ((addr < mem_total || n == 0) && n < NBLK) begin
         tbl_start[n] = addr[15:0];
         tbl_size[n] = (addr < mem_total) ? 16'(mem_total - addr) : 16'd0;
         tbl_owner[n] = '0; n++;
      end
      for (int i = n; i < NBLK; i++) begin
         tbl_start[i] = '0; tbl_size[i] = '0; tbl_owner[i] = '0;
      end
      tbl_count = n;
   endfunction

   function automatic void predict_allocator(alloc_cmd_type c);
      logic [2:0]  rc;
      logic [15:0] gs;
      case (c.operation)
         cma_pkg::OP_REQUEST: begin
            rc = grant(c.owner_id, c.request_size, c.fit_strategy, gs);
            if (rc == cma_pkg::RC_OK) queue_word(mk_rsp(rc, gs, c.request_size,
                                                        c.owner_id, 1));
            else queue_word(mk_rsp(rc, 0, 0, 0, 1));
         end
         cma_pkg::OP_RELEASE: queue_word(mk_rsp(free_owner(c.owner_id), 0, 0, 0, 1));
         cma_pkg::OP_COMPACT: begin
            pack_table();
            queue_word(mk_rsp(cma_pkg::RC_OK, 0, 0, 0, 1));
         end
         default: begin
            for (int i = 0; i < tbl_count; i++)
               queue_word(mk_rsp(cma_pkg::RC_OK, tbl_start[i], tbl_size[i], tbl_owner[i],
                                 i + 1 == tbl_count));
         end
      endcase
   endfunction

   // response checker
   always @(posedge clock) begin
      alloc_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response word");
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_result_code !== want.result_code) begin
               $error("result_code exp %0d got %0d", want.result_code, rsp_result_code);
               errors++;
            end
            if (rsp_block_start !== want.block_start) begin
               $error("block_start exp %0d got %0d", want.block_start, rsp_block_start);
               errors++;
            end
            if (rsp_block_size !== want.block_size) begin
               $error("block_size exp %0d got %0d", want.block_size, rsp_block_size);
               errors++;
            end
            if (rsp_block_owner !== want.block_owner) begin
               $error("block_owner exp %0d got %0d", want.block_owner, rsp_block_owner);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last exp %0d got %0d", want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (hold_rsp) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic send_cmd(alloc_cmd_type c);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= c.operation;
      req_owner_id <= c.owner_id;
      req_request_size <= c.request_size;
      req_fit_strategy <= c.fit_strategy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_allocator(c);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_total(logic [15:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mem_total = v;
      table_init();
      @(posedge clock);
   endtask

   function automatic alloc_cmd_type mk_cmd(logic [1:0] op, logic [7:0] own,
                                            logic [15:0] sz, logic [1:0] fit);
      alloc_cmd_type c;
      c.operation = op; c.owner_id = own; c.request_size = sz; c.fit_strategy = fit;
      return c;
   endfunction

   function automatic alloc_cmd_type rand_cmd();
      int r;
      logic [15:0] sz;
      r = $urandom_range(99);
      if (r < 5) sz = 16'($urandom);
      else if (r < 8) sz = '0;
      else sz = 16'($urandom_range(1, (mem_total > 4) ? mem_total / 4 : 1));
      r = $urandom_range(99);
      if (r < 55) return mk_cmd(cma_pkg::OP_REQUEST, 8'($urandom_range(1, 12)), sz,
                                ($urandom_range(19) == 0) ? FIT_INVALID
                                                          : 2'($urandom_range(2)));
      if (r < 75) return mk_cmd(cma_pkg::OP_RELEASE,
                                ($urandom_range(9) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(1, 12)),
                                16'($urandom), 2'($urandom));
      if (r < 85) return mk_cmd(cma_pkg::OP_COMPACT, 8'($urandom), 16'($urandom),
                                2'($urandom));
      return mk_cmd(cma_pkg::OP_STATUS, 8'($urandom), 16'($urandom), 2'($urandom));
   endfunction

   directed_row_type directed [] = '{
      '{mk_cmd(cma_pkg::OP_STATUS, 0, 0, 0), 1,
        mk_rsp(cma_pkg::RC_OK, 0, 16'hFFFF, 0, 1)},
      '{mk_cmd(cma_pkg::OP_REQUEST, 1, 10, FIT_INVALID), 1,
        mk_rsp(cma_pkg::RC_BADFIT, 0, 0, 0, 1)},
      '{mk_cmd(cma_pkg::OP_REQUEST, 0, 10, cma_pkg::FIT_FIRST), 1,
        mk_rsp(cma_pkg::RC_NOOWNER, 0, 0, 0, 1)},
      '{mk_cmd(cma_pkg::OP_REQUEST, 1, 0, cma_pkg::FIT_FIRST), 1,
        mk_rsp(cma_pkg::RC_NOMEM, 0, 0, 0, 1)},
      '{mk_cmd(cma_pkg::OP_RELEASE, 0, 0, 0), 1,
        mk_rsp(cma_pkg::RC_NOOWNER, 0, 0, 0, 1)},
      '{mk_cmd(cma_pkg::OP_RELEASE, 9, 0, 0), 1,
        mk_rsp(cma_pkg::RC_NOOWNER, 0, 0, 0, 1)},
      '{mk_cmd(cma_pkg::OP_REQUEST, 1, 100, cma_pkg::FIT_FIRST), 1,
        mk_rsp(cma_pkg::RC_OK, 0, 100, 1, 1)},
      '{mk_cmd(cma_pkg::OP_REQUEST, 2, 50, cma_pkg::FIT_BEST), 1,
        mk_rsp(cma_pkg::RC_OK, 100, 50, 2, 1)},
      '{mk_cmd(cma_pkg::OP_REQUEST, 3, 200, cma_pkg::FIT_WORST), 0, '0},
      '{mk_cmd(cma_pkg::OP_REQUEST, 255, 20, cma_pkg::FIT_FIRST), 0, '0},
      '{mk_cmd(cma_pkg::OP_RELEASE, 2, 0, 0), 0, '0},
      '{mk_cmd(cma_pkg::OP_REQUEST, 4, 16'hFFFF, cma_pkg::FIT_FIRST), 1,
        mk_rsp(cma_pkg::RC_NOMEM, 0, 0, 0, 1)},
      '{mk_cmd(cma_pkg::OP_REQUEST, 5, 30, cma_pkg::FIT_BEST), 0, '0},
      '{mk_cmd(cma_pkg::OP_REQUEST, 6, 20, cma_pkg::FIT_WORST), 0, '0},
      '{mk_cmd(cma_pkg::OP_STATUS, 0, 0, 0), 0, '0},
      '{mk_cmd(cma_pkg::OP_RELEASE, 1, 16'hFFFF, FIT_INVALID), 0, '0},
      '{mk_cmd(cma_pkg::OP_COMPACT, 8'hFF, 16'hFFFF, FIT_INVALID), 0, '0},
      '{mk_cmd(cma_pkg::OP_STATUS, 8'hFF, 16'hFFFF, FIT_INVALID), 0, '0}
   };

   initial begin
      int busy;
      alloc_cmd_type c;
      mem_total = cma_pkg::TOTAL_RESET;
      table_init();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle = 10; recv_idle = 63;
      foreach (directed[i]) begin
         send_cmd(directed[i].cmd);
         // typed-in result stands in for the predicted word
         if (directed[i].known) pending_rsp[pending_rsp.size()-1] = directed[i].rsp;
      end
      drain();

      // table full: many small grants in a small memory
      write_total(16'd40);
      for (int i = 0; i < 20; i++)
         send_cmd(mk_cmd(cma_pkg::OP_REQUEST, 8'(i + 1), 1, cma_pkg::FIT_FIRST));
      send_cmd(mk_cmd(cma_pkg::OP_STATUS, 0, 0, 0));
      send_cmd(mk_cmd(cma_pkg::OP_COMPACT, 0, 0, 0));
      drain();

      // zero total size: compaction keeps a single free entry of size zero
      write_total(16'd0);
      send_cmd(mk_cmd(cma_pkg::OP_COMPACT, 0, 0, 0));
      send_cmd(mk_cmd(cma_pkg::OP_REQUEST, 1, 1, cma_pkg::FIT_FIRST));
      send_cmd(mk_cmd(cma_pkg::OP_STATUS, 0, 0, 0));
      drain();

      write_total(16'd1);
      send_cmd(mk_cmd(cma_pkg::OP_REQUEST, 7, 1, cma_pkg::FIT_BEST));
      send_cmd(mk_cmd(cma_pkg::OP_COMPACT, 0, 0, 0));
      send_cmd(mk_cmd(cma_pkg::OP_STATUS, 0, 0, 0));
      drain();

      // stall the result side for a long time while words keep coming
      write_total(16'd1000);
      hold_rsp <= 1'b1;
      fork
         begin
            busy = 0;
            while (busy < 2000) begin
               @(posedge clock);
               busy++;
            end
            hold_rsp <= 1'b0;
         end
         for (int i = 0; i < 8; i++) send_cmd(mk_cmd(cma_pkg::OP_STATUS, 0, 0, 0));
      join
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle = 10; recv_idle = 63; write_total(16'd500); end
            1: begin send_idle = 63; recv_idle = 10; write_total(16'hFFFF); end
            default: begin send_idle = 0; recv_idle = 0; write_total(16'd64); end
         endcase
         for (int i = 0; i < 50; i++) begin
            c = rand_cmd();
            send_cmd(c);
         end
         drain();
      end

      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire
